@@ rtl/hue_colorized_depth_decode_top_macros.svh @@
// Assertion macros for the hue depth decoder.
// Used by the top level; no other dependencies.
`ifndef HUE_COLORIZED_DEPTH_DECODE_TOP_MACROS_SVH
`define HUE_COLORIZED_DEPTH_DECODE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define HCDD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define HCDD_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("assertion failed");
`else
`define HCDD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define HCDD_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

@@ rtl/hcdd_pkg.sv @@
// Shared constants and types for the hue depth decoder.
// No dependencies.
`timescale 1ns / 1ps
package hcdd_pkg;
    localparam logic [10:0] HUE_SPAN       = 11'd1529;
    localparam logic [10:0] HUE_GREEN_BASE = 11'd510;
    localparam logic [10:0] HUE_BLUE_BASE  = 11'd1020;
    localparam logic [9:0]  DARK_LIMIT     = 10'd128;
    localparam logic [16:0] NEAR_OFFSET_MM = 17'd100;
    localparam logic [9:0]  MM_TO_UM       = 10'd1000;
    localparam int NUM_W = 55;
    localparam int DEN_W = 46;
    localparam int Q_W   = 16;
    localparam int CMP_W = DEN_W + Q_W;

    localparam logic [3:0] ADDR_MODE = 4'd0;
    localparam logic [3:0] ADDR_MIN  = 4'd4;
    localparam logic [3:0] ADDR_MAX  = 4'd8;
    localparam logic [3:0] ADDR_UNIT = 4'd12;

    localparam logic MODE_DEPTH     = 1'b0;
    localparam logic MODE_DISPARITY = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [15:0] min_mm;
        logic [15:0] max_mm;
        logic [15:0] unit_um;
    } cfg_t;
endpackage

@@ rtl/hcdd_cfg.sv @@
// APB register file holding the decoder configuration.
// Depends on hcdd_pkg.
`timescale 1ns / 1ps
module hcdd_cfg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output hcdd_pkg::cfg_t    cfg
);
    import hcdd_pkg::*;

    cfg_t cfg_reg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode    <= MODE_DISPARITY;
            cfg_reg.min_mm  <= 16'd290;
            cfg_reg.max_mm  <= 16'd10000;
            cfg_reg.unit_um <= 16'd1000;
        end
        else if (wr_en)
        begin
            case (paddr)
                ADDR_MODE: cfg_reg.mode    <= pwdata[0];
                ADDR_MIN:  cfg_reg.min_mm  <= pwdata[15:0];
                ADDR_MAX:  cfg_reg.max_mm  <= pwdata[15:0];
                ADDR_UNIT: cfg_reg.unit_um <= pwdata[15:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr)
            ADDR_MODE: prdata = {31'd0, cfg_reg.mode};
            ADDR_MIN:  prdata = {16'd0, cfg_reg.min_mm};
            ADDR_MAX:  prdata = {16'd0, cfg_reg.max_mm};
            ADDR_UNIT: prdata = {16'd0, cfg_reg.unit_um};
            default:   prdata = 32'd0;
        endcase
    end
endmodule

@@ rtl/hcdd_hue.sv @@
// Input register stage: decodes the pixel hue to a code.
// Depends on hcdd_pkg.
`timescale 1ns / 1ps
module hcdd_hue (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_vld,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    output logic        out_vld,
    output logic [10:0] code
);
    import hcdd_pkg::*;

    logic        vld_reg;
    logic [10:0] code_reg, code_next;
    logic [9:0]  sum;
    logic [10:0] r11, g11, b11;

    assign r11 = {3'd0, red};
    assign g11 = {3'd0, green};
    assign b11 = {3'd0, blue};
    assign sum = {2'd0, red} + {2'd0, green} + {2'd0, blue};

    // differences wrap mod 2048; the true code is always in range
    always_comb
    begin
        if (sum <= DARK_LIMIT)
            code_next = 11'd0;
        else if (red >= green && red >= blue)
            code_next = (green >= blue) ? (g11 - b11) : (g11 - b11 + HUE_SPAN);
        else if (green >= blue)
            code_next = b11 - r11 + HUE_GREEN_BASE;
        else
            code_next = r11 - g11 + HUE_BLUE_BASE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
    end

    assign out_vld = vld_reg;
    assign code    = code_reg;
endmodule

@@ rtl/hcdd_ratio.sv @@
// Four stages that build the rounded-division operands from the code.
// Depends on hcdd_pkg.
`timescale 1ns / 1ps
module hcdd_ratio (
    input  logic                      clk,
    input  logic                      rst_n,
    input  hcdd_pkg::cfg_t            cfg,
    input  logic                      in_vld,
    input  logic [10:0]               in_code,
    output logic                      out_vld,
    output logic [10:0]               out_code,
    output logic [hcdd_pkg::NUM_W-1:0] dividend,
    output logic [hcdd_pkg::DEN_W-1:0] divisor
);
    import hcdd_pkg::*;

    logic [3:0]  vld_reg;
    logic [10:0] code2_reg, code3_reg, code4_reg, code5_reg;
    logic [16:0] p;
    logic [15:0] unit;
    logic [10:0] kc;

    logic [27:0] m1_reg, m1_next;
    logic [26:0] m2_reg, m2_next;
    logic [32:0] pq_reg, pq_next;
    logic [28:0] s_reg, s_next;
    logic [43:0] pqk_reg, pqk_next;
    logic [52:0] num_reg, num_next;
    logic [44:0] den_reg, den_next;
    logic [NUM_W-1:0] n_reg, n_next;
    logic [DEN_W-1:0] d_reg, d_next;

    assign p    = {1'b0, cfg.min_mm} + NEAR_OFFSET_MM;
    assign unit = (cfg.unit_um == 16'd0) ? 16'd1 : cfg.unit_um;
    assign kc   = HUE_SPAN - in_code;

    always_comb
    begin
        m1_next  = (cfg.mode == MODE_DISPARITY) ? (28'(p) * 28'(kc))
                                                : (28'(cfg.min_mm) * 28'(kc));
        m2_next  = 27'(cfg.max_mm) * 27'(in_code);
        pq_next  = 33'(p) * 33'(cfg.max_mm);
        s_next   = 29'(m1_reg) + 29'(m2_reg);
        pqk_next = 44'(pq_reg) * 44'(HUE_SPAN);
        if (cfg.mode == MODE_DISPARITY)
        begin
            num_next = 53'(pqk_reg) * 53'(MM_TO_UM);
            den_next = 45'(s_reg) * 45'(unit);
        end
        else
        begin
            num_next = 53'(s_reg) * 53'(MM_TO_UM);
            den_next = 45'(HUE_SPAN) * 45'(unit);
        end
        // floor(num/den + 1/2) = floor((2*num + den) / (2*den))
        n_next = {{(NUM_W-54){1'b0}}, num_reg, 1'b0} + {{(NUM_W-45){1'b0}}, den_reg};
        d_next = {den_reg, 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 4'd0;
        else
            vld_reg <= {vld_reg[2:0], in_vld};
    end

    always_ff @(posedge clk)
    begin
        m1_reg    <= m1_next;
        m2_reg    <= m2_next;
        pq_reg    <= pq_next;
        code2_reg <= in_code;
        s_reg     <= s_next;
        pqk_reg   <= pqk_next;
        code3_reg <= code2_reg;
        num_reg   <= num_next;
        den_reg   <= den_next;
        code4_reg <= code3_reg;
        n_reg     <= n_next;
        d_reg     <= d_next;
        code5_reg <= code4_reg;
    end

    assign out_vld  = vld_reg[3];
    assign out_code = code5_reg;
    assign dividend = n_reg;
    assign divisor  = d_reg;
endmodule

@@ rtl/hcdd_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with overflow clamp.
// Depends on hcdd_pkg.
`timescale 1ns / 1ps
module hcdd_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_vld,
    input  logic [10:0]                in_code,
    input  logic [hcdd_pkg::NUM_W-1:0] dividend,
    input  logic [hcdd_pkg::DEN_W-1:0] divisor,
    output logic                       out_vld,
    output logic [10:0]                out_code,
    output logic [15:0]                out_depth,
    output logic                       out_clamped
);
    import hcdd_pkg::*;

    localparam int NS = Q_W + 1;

    logic             vld_reg  [NS];
    logic [10:0]      code_reg [NS];
    logic [NUM_W-1:0] rem_reg  [NS];
    logic [NUM_W-1:0] rem_next [NS];
    logic [DEN_W-1:0] d_reg    [NS];
    logic [Q_W-1:0]   q_reg    [NS];
    logic [Q_W-1:0]   q_next   [NS];
    logic             ovf_reg  [NS];
    logic             ovf0_next;

    // quotient above 16 bits saturates
    assign ovf0_next = CMP_W'(dividend) >= {divisor, {Q_W{1'b0}}};

    always_comb
    begin
        rem_next[0] = dividend;
        q_next[0]   = '0;
        for (int j = 1; j < NS; j++)
        begin
            rem_next[j] = rem_reg[j-1];
            q_next[j]   = q_reg[j-1];
            if (CMP_W'(rem_reg[j-1]) >= (CMP_W'(d_reg[j-1]) << (Q_W - j)))
            begin
                rem_next[j] = NUM_W'(CMP_W'(rem_reg[j-1])
                              - (CMP_W'(d_reg[j-1]) << (Q_W - j)));
                q_next[j][Q_W-j] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < NS; j++)
                vld_reg[j] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_vld;
            for (int j = 1; j < NS; j++)
                vld_reg[j] <= vld_reg[j-1];
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg[0] <= in_code;
        d_reg[0]    <= divisor;
        ovf_reg[0]  <= ovf0_next;
        for (int j = 0; j < NS; j++)
        begin
            rem_reg[j] <= rem_next[j];
            q_reg[j]   <= q_next[j];
        end
        for (int j = 1; j < NS; j++)
        begin
            code_reg[j] <= code_reg[j-1];
            d_reg[j]    <= d_reg[j-1];
            ovf_reg[j]  <= ovf_reg[j-1];
        end
    end

    always_comb
    begin
        if (code_reg[NS-1] == 11'd0)
        begin
            out_depth   = 16'd0;
            out_clamped = 1'b0;
        end
        else if (ovf_reg[NS-1])
        begin
            out_depth   = 16'hFFFF;
            out_clamped = 1'b1;
        end
        else
        begin
            out_depth   = q_reg[NS-1];
            out_clamped = 1'b0;
        end
    end

    assign out_vld  = vld_reg[NS-1];
    assign out_code = code_reg[NS-1];
endmodule

@@ rtl/hue_colorized_depth_decode_top.sv @@
// Hue-colorized depth decoder: one RGB pixel in, one depth value out.
// Each pixel passes the hue, ratio and divider stages in that order.
// Throughput: one pixel per clock, busy stays low.
// The result comes out of a fixed pipeline; the receiver cannot stall it.
// Reset (rst_n, asynchronous) clears all valid bits and loads the default
// configuration; no clearing pass. Depends on hcdd_pkg and the submodules.
`timescale 1ns / 1ps
`include "hue_colorized_depth_decode_top_macros.svh"
module hue_colorized_depth_decode_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    output logic        strobe,
    output logic [15:0] depth_units,
    output logic [10:0] hue_code,
    output logic        clamped,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import hcdd_pkg::*;

    cfg_t             cfg;
    logic             hue_vld;
    logic [10:0]      hue_cd;
    logic             rat_vld;
    logic [10:0]      rat_cd;
    logic [NUM_W-1:0] rat_n;
    logic [DEN_W-1:0] rat_d;

    assign busy = 1'b0;

    hcdd_cfg u_cfg (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
    );

    hcdd_hue u_hue (
        .clk(clk), .rst_n(rst_n), .in_vld(start && !busy),
        .red(red), .green(green), .blue(blue), .out_vld(hue_vld), .code(hue_cd)
    );

    hcdd_ratio u_ratio (
        .clk(clk), .rst_n(rst_n), .cfg(cfg), .in_vld(hue_vld), .in_code(hue_cd),
        .out_vld(rat_vld), .out_code(rat_cd), .dividend(rat_n), .divisor(rat_d)
    );

    hcdd_div u_div (
        .clk(clk), .rst_n(rst_n), .in_vld(rat_vld), .in_code(rat_cd),
        .dividend(rat_n), .divisor(rat_d), .out_vld(strobe), .out_code(hue_code),
        .out_depth(depth_units), .out_clamped(clamped)
    );

    `HCDD_ASSERT_IMPL(a_clamp_sat, clk, rst_n, strobe && clamped, depth_units == 16'hFFFF)
    `HCDD_ASSERT_IMPL(a_zero_code, clk, rst_n, strobe && hue_code == 11'd0,
                      depth_units == 16'd0 && !clamped)
    `HCDD_ASSERT_IMPL(a_code_range, clk, rst_n, strobe, hue_code < HUE_SPAN)
    `HCDD_ASSERT_IMPL(a_valid_flow, clk, rst_n, hue_vld, ##4 u_div.in_vld == 1'b1)
endmodule
